>>> hw/rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants for the segment intersection point pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

  // Coordinates carried by one input word: four end points, x and y each.
  localparam int FIELD_COUNT = 8;

  // Control that travels beside the payload from the cross-product front end.
  typedef struct packed {
    logic valid;
    logic hit;
  } sip_ctrl_t;

endpackage

>>> hw/rtl/sip_cross.sv
// ----------------------------------------------------------------------------
// sip_cross
// Front end: deltas, cross products, sign normalisation, strict range test
// and the rounding numerators for the two quotient lanes. Six stages.
// ----------------------------------------------------------------------------
module sip_cross #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      advance,
  input  logic                                      in_valid,
  input  logic [sip_pkg::FIELD_COUNT*COORD_BITS-1:0] in_data,
  output sip_pkg::sip_ctrl_t                        ctrl,
  output logic [3*COORD_BITS+FRAC_BITS+4:0]         num_x,
  output logic [3*COORD_BITS+FRAC_BITS+4:0]         num_y,
  output logic [2*COORD_BITS+2:0]                   den2,
  output logic                                      neg_x,
  output logic                                      neg_y,
  output logic signed [COORD_BITS-1:0]              base_x,
  output logic signed [COORD_BITS-1:0]              base_y
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;          // deltas
  localparam int PW = 2 * DW;          // products
  localparam int XW = PW + 1;          // cross differences
  localparam int UW = XW - 1;          // normalised magnitudes
  localparam int MW = CW + 1;          // |r| component
  localparam int RW = MW + UW;         // |r| * nt
  localparam int NW = 3 * CW + FRAC_BITS + 5;

  logic signed [CW-1:0] f [sip_pkg::FIELD_COUNT];
  always_comb begin
    for (int i = 0; i < sip_pkg::FIELD_COUNT; i++) begin
      f[i] = in_data[i*CW +: CW];
    end
  end

  // Stage 1: deltas
  logic v1;
  logic signed [DW-1:0] rx1, ry1, qx1, qy1, wx1, wy1;
  logic signed [CW-1:0] ax1, ay1;
  // Stage 2: products and |r|
  logic v2;
  logic signed [PW-1:0] p_rq, p_rq2, p_wq, p_wq2, p_wr, p_wr2;
  logic [MW-1:0] mx2, my2;
  logic nx2, ny2;
  logic signed [CW-1:0] ax2, ay2;
  // Stage 3: cross differences
  logic v3;
  logic signed [XW-1:0] d3, nt3, ns3;
  logic [MW-1:0] mx3, my3;
  logic nx3, ny3;
  logic signed [CW-1:0] ax3, ay3;
  // Stage 4: make d positive
  logic v4, nz4;
  logic signed [XW-1:0] d4, nt4, ns4;
  logic [MW-1:0] mx4, my4;
  logic nx4, ny4;
  logic signed [CW-1:0] ax4, ay4;
  // Stage 5: strict test and |r| * nt
  logic v5, h5;
  logic [RW-1:0] px5, py5;
  logic [UW-1:0] d5;
  logic nx5, ny5;
  logic signed [CW-1:0] ax5, ay5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ctrl <= '0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      ctrl.valid <= v5;
      ctrl.hit   <= h5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rx1 <= DW'(f[2]) - DW'(f[0]);
      ry1 <= DW'(f[3]) - DW'(f[1]);
      qx1 <= DW'(f[6]) - DW'(f[4]);
      qy1 <= DW'(f[7]) - DW'(f[5]);
      wx1 <= DW'(f[4]) - DW'(f[0]);
      wy1 <= DW'(f[5]) - DW'(f[1]);
      ax1 <= f[0];
      ay1 <= f[1];

      p_rq  <= PW'(rx1) * PW'(qy1);
      p_rq2 <= PW'(ry1) * PW'(qx1);
      p_wq  <= PW'(wx1) * PW'(qy1);
      p_wq2 <= PW'(wy1) * PW'(qx1);
      p_wr  <= PW'(wx1) * PW'(ry1);
      p_wr2 <= PW'(wy1) * PW'(rx1);
      mx2 <= rx1[DW-1] ? MW'(-rx1) : MW'(rx1);
      my2 <= ry1[DW-1] ? MW'(-ry1) : MW'(ry1);
      nx2 <= rx1[DW-1];
      ny2 <= ry1[DW-1];
      ax2 <= ax1;
      ay2 <= ay1;

      d3  <= XW'(p_rq) - XW'(p_rq2);
      nt3 <= XW'(p_wq) - XW'(p_wq2);
      ns3 <= XW'(p_wr) - XW'(p_wr2);
      mx3 <= mx2;
      my3 <= my2;
      nx3 <= nx2;
      ny3 <= ny2;
      ax3 <= ax2;
      ay3 <= ay2;

      // flip all three when d is negative
      d4  <= d3[XW-1] ? -d3 : d3;
      nt4 <= d3[XW-1] ? -nt3 : nt3;
      ns4 <= d3[XW-1] ? -ns3 : ns3;
      nz4 <= (d3 != '0);
      mx4 <= mx3;
      my4 <= my3;
      nx4 <= nx3;
      ny4 <= ny3;
      ax4 <= ax3;
      ay4 <= ay3;

      h5  <= nz4 && (nt4 > 0) && (nt4 < d4) && (ns4 > 0) && (ns4 < d4);
      px5 <= RW'(mx4) * RW'(nt4[UW-1:0]);
      py5 <= RW'(my4) * RW'(nt4[UW-1:0]);
      d5  <= d4[UW-1:0];
      nx5 <= nx4;
      ny5 <= ny4;
      ax5 <= ax4;
      ay5 <= ay4;

      // numerator |r|*nt*2^(F+1) + d over 2d gives the rounded quotient
      num_x  <= (NW'(px5) << (FRAC_BITS + 1)) + NW'(d5);
      num_y  <= (NW'(py5) << (FRAC_BITS + 1)) + NW'(d5);
      den2   <= {d5, 1'b0};
      neg_x  <= nx5;
      neg_y  <= ny5;
      base_x <= ax5;
      base_y <= ay5;
    end
  end

endmodule

>>> hw/rtl/sip_divider.sv
// ----------------------------------------------------------------------------
// sip_divider
// One quotient lane: restoring division, one quotient bit per stage, then
// sign, offset by the start point and zero the result on a miss.
// ----------------------------------------------------------------------------
module sip_divider #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  sip_pkg::sip_ctrl_t                    in_ctrl,
  input  logic [3*COORD_BITS+FRAC_BITS+4:0]     in_num,
  input  logic [2*COORD_BITS+2:0]               in_den,
  input  logic                                  in_neg,
  input  logic signed [COORD_BITS-1:0]          in_base,
  output sip_pkg::sip_ctrl_t                    out_ctrl,
  output logic [COORD_BITS+FRAC_BITS-1:0]       out_coord
);

  localparam int CW  = COORD_BITS;
  localparam int NW  = 3 * CW + FRAC_BITS + 5;
  localparam int DVW = 2 * CW + 3;
  localparam int QB  = CW + FRAC_BITS + 1;
  localparam int OW  = CW + FRAC_BITS;
  localparam int SW  = OW + 2;

  logic [NW-1:0]        num_q  [QB];
  logic [DVW-1:0]       den_q  [QB];
  logic [QB-1:0]        quo_q  [QB];
  logic                 neg_q  [QB];
  logic signed [CW-1:0] base_q [QB];
  sip_pkg::sip_ctrl_t   ctrl_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [NW-1:0]        num_i, trial;
    logic [DVW-1:0]       den_i;
    logic [QB-1:0]        quo_i;
    logic                 neg_i, ge;
    logic signed [CW-1:0] base_i;
    sip_pkg::sip_ctrl_t   ctrl_i;

    if (k == 0) begin : g_first
      assign num_i  = in_num;
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign neg_i  = in_neg;
      assign base_i = in_base;
      assign ctrl_i = in_ctrl;
    end else begin : g_next
      assign num_i  = num_q[k-1];
      assign den_i  = den_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign neg_i  = neg_q[k-1];
      assign base_i = base_q[k-1];
      assign ctrl_i = ctrl_q[k-1];
    end

    assign trial = NW'(den_i) << B;
    assign ge    = (num_i >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[k] <= '0;
      end else if (advance) begin
        ctrl_q[k] <= ctrl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        num_q[k]  <= ge ? num_i - trial : num_i;
        quo_q[k]  <= quo_i | (ge ? (QB'(1) << B) : QB'(0));
        den_q[k]  <= den_i;
        neg_q[k]  <= neg_i;
        base_q[k] <= base_i;
      end
    end
  end

  logic signed [SW-1:0] sq, sum;
  assign sq  = neg_q[QB-1] ? -SW'(quo_q[QB-1]) : SW'(quo_q[QB-1]);
  assign sum = (SW'(base_q[QB-1]) <<< FRAC_BITS) + sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (advance) begin
      out_ctrl <= ctrl_q[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_coord <= ctrl_q[QB-1].hit ? sum[OW-1:0] : '0;
    end
  end

endmodule

>>> hw/rtl/segment_intersection_point.sv
// Pipeline: six front-end stages, one stage per quotient bit, and the output
//   register, from input word to output word.
// Throughput: one word per cycle; a stalled output word holds the whole pipe.
// Reset: rst, synchronous, clears every valid bit; payload is not reset.
// ----------------------------------------------------------------------------
// segment_intersection_point
// Strict crossing point of two 2-D segments, rounded to FRAC_BITS fractions.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // s_axis_tdata, lowest bit up: first_start_x, first_start_y, first_end_x,
  // first_end_y, second_start_x, second_start_y, second_end_x, second_end_y
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((sip_pkg::FIELD_COUNT*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // m_axis_tdata, lowest bit up: cross_x, cross_y, zero fill
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((2*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
  // m_axis_tuser: found
  output logic                                     m_axis_tuser
);

  localparam int IW  = sip_pkg::FIELD_COUNT * COORD_BITS;
  localparam int OW  = COORD_BITS + FRAC_BITS;
  localparam int OTW = ((2 * OW + 7) / 8) * 8;
  localparam int NW  = 3 * COORD_BITS + FRAC_BITS + 5;
  localparam int DVW = 2 * COORD_BITS + 3;

  // Advance the whole pipe unless the output word is held by the sink.
  logic advance;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  sip_pkg::sip_ctrl_t   fe_ctrl, x_ctrl, y_ctrl;
  logic [NW-1:0]        num_x, num_y;
  logic [DVW-1:0]       den2;
  logic                 neg_x, neg_y;
  logic signed [COORD_BITS-1:0] base_x, base_y;
  logic [OW-1:0]        cross_x, cross_y;

  sip_cross #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata[IW-1:0]),
    .ctrl     (fe_ctrl),
    .num_x    (num_x),
    .num_y    (num_y),
    .den2     (den2),
    .neg_x    (neg_x),
    .neg_y    (neg_y),
    .base_x   (base_x),
    .base_y   (base_y)
  );

  // Two identical quotient lanes, one per coordinate.
  sip_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_ctrl   (fe_ctrl),
    .in_num    (num_x),
    .in_den    (den2),
    .in_neg    (neg_x),
    .in_base   (base_x),
    .out_ctrl  (x_ctrl),
    .out_coord (cross_x)
  );

  sip_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_ctrl   (fe_ctrl),
    .in_num    (num_y),
    .in_den    (den2),
    .in_neg    (neg_y),
    .in_base   (base_y),
    .out_ctrl  (y_ctrl),
    .out_coord (cross_y)
  );

  // The lanes run in lock step; their output registers form the output word.
  assign m_axis_tvalid = x_ctrl.valid & y_ctrl.valid;
  assign m_axis_tuser  = x_ctrl.hit & y_ctrl.hit;
  assign m_axis_tdata  = OTW'({cross_y, cross_x});

endmodule

>>> hw/rtl/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks for segment_intersection_point, bound to the top level.
// ----------------------------------------------------------------------------
module sip_checker #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 8
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((2*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser
);

  // A held output word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // A miss reports the origin.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with non-zero point");

  // A stalled output stops intake.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Reset empties the pipe.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind segment_intersection_point sip_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_sip_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
